// ----- sv/ilts_pkg.sv -----
// Shared types and constants of the luminance and texture statistics block.
`timescale 1ns / 1ps
package ilts_pkg;

	// Operation of the shared arithmetic unit.
	typedef enum logic [2:0] {
		ALU_MUL  = 3'b001,
		ALU_DIV  = 3'b010,
		ALU_SQRT = 3'b100
	} alu_op_t;

	localparam int STEP_W = 7;

	typedef struct packed {
		logic              start;
		alu_op_t           op;
		logic [STEP_W-1:0] steps;
	} alu_ctl_t;

	// Rec.709 weights in Q0.16, summing to 65536.
	localparam logic [15:0] LUMA_KR  = 16'd13933;
	localparam logic [15:0] LUMA_KG  = 16'd46871;
	localparam logic [15:0] LUMA_KB  = 16'd4732;
	localparam logic [7:0]  LUMA_RND = 8'd128;

	localparam logic [21:0] VAR_CAP = 22'd4161536;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_THRESH = 2'd2;

	localparam logic [12:0] WIDTH_RST  = 13'd640;
	localparam logic [12:0] HEIGHT_RST = 13'd480;
	localparam logic [16:0] THRESH_RST = 17'd11750;

	// Quotient bits of each division and square root sizing.
	localparam int MEAN_QB    = 16;
	localparam int VAR_QB     = 23;
	localparam int FRAC_QB    = 17;
	localparam int ROOT_STEPS = 17;
	localparam int ROOT_TOP   = 32;

endpackage

// ----- sv/image_luminance_texture_stats_core.sv -----
// Top level of the frame luminance and texture statistics block.
`timescale 1ns / 1ps
// Pixels stream in raster order as RGB beats; each is turned into Rec.709
// luminance in 8.8 units and summed, with its square, over the frame. The
// luminance of every even row is kept in a row RAM, and at every even column
// that has a right neighbour in the following odd row the gradient magnitude
// against the right and down neighbours is taken through a rounded square
// root, summed as texture and compared with the threshold register. After
// the last pixel one result beat carries the mean, the variance, the edge
// density, the mean texture and the number of sample points. A pixel is
// taken only when the sequencer is idle, after the previous one is done. The
// 17-step square root of a sample point runs in the shared iterative unit, as
// do the two shift-add multiplies and four divisions at the end of a frame;
// the row RAM read port is used twice per sample point. A write to any
// register restarts the frame; the user must write registers only while the
// block is idle, which the block itself does not enforce.
module image_luminance_texture_stats_core #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: red [7:0], green [15:8], blue [23:16]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,
	// m_tdata: luma_mean [15:0], luma_var [37:16],
	// edge_ratio [54:38], mean_texture [71:55], sample_points [94:72], zero [95]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import ilts_pkg::*;

	localparam int EW   = $clog2(MAX_WIDTH + 1);
	localparam int EH   = $clog2(MAX_HEIGHT + 1);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int PW   = EW + EH;
	localparam int SUMW = PW + 16;
	localparam int SQW  = PW + 32;
	localparam int TW   = PW + 17;
	localparam int W    = 2 * PW + 34;

	typedef enum logic [16:0] {
		ST_IDLE = 17'b00000000000000001,
		ST_LUMA = 17'b00000000000000010,
		ST_ACC  = 17'b00000000000000100,
		ST_DIFF = 17'b00000000000001000,
		ST_SQR  = 17'b00000000000010000,
		ST_ROOT = 17'b00000000000100000,
		ST_TEX  = 17'b00000000001000000,
		ST_ADV  = 17'b00000000010000000,
		ST_PIX  = 17'b00000000100000000,
		ST_DSQ  = 17'b00000001000000000,
		ST_MEAN = 17'b00000010000000000,
		ST_MUL1 = 17'b00000100000000000,
		ST_MUL2 = 17'b00001000000000000,
		ST_VDIV = 17'b00010000000000000,
		ST_EDGE = 17'b00100000000000000,
		ST_TDIV = 17'b01000000000000000,
		ST_OUT  = 17'b10000000000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [16:0] thresh_q;

	// Frame position and accumulators.
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [SUMW-1:0] sum_q;
	logic [SQW-1:0]  sq_q;
	logic [TW-1:0]   tex_q;
	logic [PW-1:0]   hit_q;
	logic [PW-1:0]   smp_q;
	logic            launched_q;
	logic            m_valid_q;

	// Per-pixel and end-of-frame working registers.
	logic [7:0]      red_q;
	logic [7:0]      green_q;
	logic [7:0]      blue_q;
	logic [15:0]     luma_q;
	logic [15:0]     here_q;
	logic [15:0]     dx_q;
	logic [15:0]     dy_q;
	logic [33:0]     s_q;
	logic [16:0]     mag_q;
	logic [PW-1:0]   pix_q;
	logic [2*PW-1:0] dsq_q;
	logic [W-1:0]    prod1_q;
	logic [W-1:0]    prod2_q;
	logic [15:0]     mean_q;
	logic [21:0]     var_q;
	logic [16:0]     edge_q;
	logic [16:0]     texm_q;
	logic [95:0]     out_q;

	logic [EW-1:0] weff;
	logic [EH-1:0] heff;
	logic          col_more;
	logic          row_more;
	logic          sample;
	logic          cfg_wr;
	logic          cfg_hit;
	logic          out_fire;
	logic          frame_clr;
	logic          op_state;
	logic          skip;
	logic [23:0]   luma_full;

	logic          ram_we;
	logic [CW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	alu_ctl_t      alu_ctl;
	logic [W-1:0]  alu_a;
	logic [W-1:0]  alu_b;
	logic          alu_done;
	logic [W-1:0]  alu_res;

	// Size clamping: zero is one, above the maximum is the maximum.
	always_comb begin
		if (width_q == '0) begin
			weff = EW'(1);
		end else if ({1'b0, width_q} > 14'(MAX_WIDTH)) begin
			weff = EW'(MAX_WIDTH);
		end else begin
			weff = EW'(width_q);
		end
		if (height_q == '0) begin
			heff = EH'(1);
		end else if ({1'b0, height_q} > 14'(MAX_HEIGHT)) begin
			heff = EH'(MAX_HEIGHT);
		end else begin
			heff = EH'(height_q);
		end
	end

	assign col_more = ((EW+1)'(col_q) + (EW+1)'(1)) < (EW+1)'(weff);
	assign row_more = ((EH+1)'(row_q) + (EH+1)'(1)) < (EH+1)'(heff);
	assign sample   = row_q[0] & ~col_q[0] & col_more;

	assign luma_full = 24'(red_q) * 24'(LUMA_KR) + 24'(green_q) * 24'(LUMA_KG)
		+ 24'(blue_q) * 24'(LUMA_KB) + 24'(LUMA_RND);

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_hit = cfg_wr & (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT
		|| paddr[3:2] == REG_THRESH);

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_THRESH: prdata = 32'(thresh_q);
			default:    prdata = '0;
		endcase
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = out_q;
	assign out_fire  = (state_q == ST_OUT) & (~m_valid_q | m_tready);
	assign frame_clr = cfg_hit | out_fire;

	// Row store: even rows write, odd rows read here and then the right neighbour.
	assign ram_we    = (state_q == ST_ACC) & ~row_q[0];
	assign ram_raddr = (state_q == ST_ACC) ? col_q + CW'(1) : col_q;

	ilts_ram #(
		.WIDTH (16),
		.DEPTH (MAX_WIDTH)
	) u_row (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q),
		.wdata (luma_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Operand selection for the shared unit.
	assign op_state = (state_q == ST_ROOT) || (state_q == ST_MEAN) || (state_q == ST_MUL1)
		|| (state_q == ST_MUL2) || (state_q == ST_VDIV) || (state_q == ST_EDGE)
		|| (state_q == ST_TDIV);

	always_comb begin
		case (state_q)
			ST_VDIV: skip = prod1_q < prod2_q;
			ST_EDGE: skip = smp_q == '0;
			ST_TDIV: skip = smp_q == '0;
			default: skip = 1'b0;
		endcase
	end

	always_comb begin
		alu_ctl.start = op_state & ~launched_q & ~skip;
		alu_ctl.op    = ALU_DIV;
		alu_ctl.steps = STEP_W'(FRAC_QB);
		alu_a         = W'(tex_q) + W'(smp_q >> 1);
		alu_b         = W'(smp_q) << (FRAC_QB - 1);
		case (state_q)
			ST_ROOT: begin
				alu_ctl.op    = ALU_SQRT;
				alu_ctl.steps = STEP_W'(ROOT_STEPS);
				alu_a         = W'(s_q);
				alu_b         = W'(1) << ROOT_TOP;
			end
			ST_MEAN: begin
				alu_ctl.steps = STEP_W'(MEAN_QB);
				alu_a         = W'(sum_q) + W'(pix_q >> 1);
				alu_b         = W'(pix_q) << (MEAN_QB - 1);
			end
			ST_MUL1: begin
				alu_ctl.op    = ALU_MUL;
				alu_ctl.steps = STEP_W'(PW);
				alu_a         = W'(sq_q);
				alu_b         = W'(pix_q);
			end
			ST_MUL2: begin
				alu_ctl.op    = ALU_MUL;
				alu_ctl.steps = STEP_W'(SUMW);
				alu_a         = W'(sum_q);
				alu_b         = W'(sum_q);
			end
			ST_VDIV: begin
				// Numerator carries half the divisor for rounding.
				alu_ctl.steps = STEP_W'(VAR_QB);
				alu_a         = prod1_q - prod2_q + (W'(dsq_q) << 7);
				alu_b         = W'(dsq_q) << (8 + VAR_QB - 1);
			end
			ST_EDGE: begin
				alu_a = (W'(hit_q) << 16) + W'(smp_q >> 1);
			end
			default: begin
				alu_a = W'(tex_q) + W'(smp_q >> 1);
			end
		endcase
	end

	ilts_alu #(
		.W (W)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.opa    (alu_a),
		.opb    (alu_b),
		.done   (alu_done),
		.result (alu_res)
	);

	// Sequencer, configuration and frame accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
			thresh_q   <= THRESH_RST;
			col_q      <= '0;
			row_q      <= '0;
			sum_q      <= '0;
			sq_q       <= '0;
			tex_q      <= '0;
			hit_q      <= '0;
			smp_q      <= '0;
			launched_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			// The output beat is loaded when the result fires and held until taken.
			m_valid_q <= out_fire | (m_valid_q & ~m_tready);
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_WIDTH:  width_q  <= pwdata[12:0];
					REG_HEIGHT: height_q <= pwdata[12:0];
					REG_THRESH: thresh_q <= pwdata[16:0];
					default:    thresh_q <= thresh_q;
				endcase
			end
			if (op_state) begin
				if (skip) begin
					launched_q <= 1'b0;
				end else if (!launched_q) begin
					launched_q <= 1'b1;
				end else if (alu_done) begin
					launched_q <= 1'b0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_LUMA;
					end
				end
				ST_LUMA: state_q <= ST_ACC;
				ST_ACC: begin
					sum_q   <= sum_q + SUMW'(luma_q);
					sq_q    <= sq_q + SQW'(32'(luma_q) * 32'(luma_q));
					state_q <= sample ? ST_DIFF : ST_ADV;
				end
				ST_DIFF: state_q <= ST_SQR;
				ST_SQR:  state_q <= ST_ROOT;
				ST_ROOT: begin
					if (launched_q && alu_done) begin
						state_q <= ST_TEX;
					end
				end
				ST_TEX: begin
					tex_q <= tex_q + TW'(mag_q);
					if (mag_q > thresh_q) begin
						hit_q <= hit_q + PW'(1);
					end
					smp_q   <= smp_q + PW'(1);
					state_q <= ST_ADV;
				end
				ST_ADV: begin
					if (col_more) begin
						col_q   <= col_q + CW'(1);
						state_q <= ST_IDLE;
					end else begin
						col_q <= '0;
						if (row_more) begin
							row_q   <= row_q + RW'(1);
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_PIX;
						end
					end
				end
				ST_PIX: state_q <= ST_DSQ;
				ST_DSQ: state_q <= ST_MEAN;
				ST_MEAN: begin
					if (launched_q && alu_done) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					if (launched_q && alu_done) begin
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					if (launched_q && alu_done) begin
						state_q <= ST_VDIV;
					end
				end
				ST_VDIV: begin
					if (skip || (launched_q && alu_done)) begin
						state_q <= ST_EDGE;
					end
				end
				ST_EDGE: begin
					if (skip || (launched_q && alu_done)) begin
						state_q <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					if (skip || (launched_q && alu_done)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (frame_clr) begin
				col_q <= '0;
				row_q <= '0;
				sum_q <= '0;
				sq_q  <= '0;
				tex_q <= '0;
				hit_q <= '0;
				smp_q <= '0;
			end
		end
	end

	// Working registers without reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				red_q   <= s_tdata[7:0];
				green_q <= s_tdata[15:8];
				blue_q  <= s_tdata[23:16];
			end
			ST_LUMA: luma_q <= luma_full[23:8];
			ST_ACC:  here_q <= ram_rdata;
			ST_DIFF: begin
				dx_q <= (here_q > ram_rdata) ? here_q - ram_rdata : ram_rdata - here_q;
				dy_q <= (here_q > luma_q) ? here_q - luma_q : luma_q - here_q;
			end
			ST_SQR: s_q <= 34'(32'(dx_q) * 32'(dx_q)) + 34'(32'(dy_q) * 32'(dy_q));
			ST_ROOT: begin
				if (alu_done) begin
					mag_q <= alu_res[16:0];
				end
			end
			ST_PIX: pix_q <= PW'(weff) * PW'(heff);
			ST_DSQ: dsq_q <= (2*PW)'(pix_q) * (2*PW)'(pix_q);
			ST_MEAN: begin
				if (alu_done) begin
					mean_q <= alu_res[15:0];
				end
			end
			ST_MUL1: begin
				if (alu_done) begin
					prod1_q <= alu_res;
				end
			end
			ST_MUL2: begin
				if (alu_done) begin
					prod2_q <= alu_res;
				end
			end
			ST_VDIV: begin
				if (skip) begin
					var_q <= '0;
				end else if (alu_done) begin
					var_q <= (alu_res > W'(VAR_CAP)) ? VAR_CAP : alu_res[21:0];
				end
			end
			ST_EDGE: begin
				if (skip) begin
					edge_q <= '0;
				end else if (alu_done) begin
					edge_q <= alu_res[16:0];
				end
			end
			ST_TDIV: begin
				if (skip) begin
					texm_q <= '0;
				end else if (alu_done) begin
					texm_q <= alu_res[16:0];
				end
			end
			ST_OUT: begin
				if (out_fire) begin
					out_q <= {1'b0, 23'(smp_q), texm_q, edge_q, var_q, mean_q};
				end
			end
			default: luma_q <= luma_q;
		endcase
	end

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_done_launched: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> launched_q)
		else $error("shared unit finished without a launched operation");

	a_idle_no_op: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !launched_q)
		else $error("pixel accepted while an operation is in flight");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(EW+1)'(col_q) < (EW+1)'(weff))
		else $error("column counter beyond the frame width");
`endif

endmodule

// ----- sv/ilts_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module ilts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/ilts_alu.sv -----
// Shared iterative unit: shift-add multiply, restoring divide, rounded square root.
`timescale 1ns / 1ps
module ilts_alu #(
	parameter int W = 84
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ilts_pkg::alu_ctl_t ctl,
	input  logic [W-1:0]      opa,
	input  logic [W-1:0]      opb,
	output logic              done,
	output logic [W-1:0]      result
);

	import ilts_pkg::*;

	logic              busy_q;
	logic              done_q;
	alu_op_t           op_q;
	logic [STEP_W-1:0] cnt_q;
	logic [W-1:0]      x_q;
	logic [W-1:0]      y_q;
	logic [W-1:0]      acc_q;
	logic [W:0]        diff;
	logic [W-1:0]      trial;
	logic [W-1:0]      msum;

	assign diff  = {1'b0, x_q} - {1'b0, y_q};
	assign trial = acc_q + y_q;
	assign msum  = acc_q + x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ALU_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				cnt_q  <= ctl.steps;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q   <= opa;
			y_q   <= opb;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				case (op_q)
					ALU_MUL: begin
						if (y_q[0]) begin
							acc_q <= msum;
						end
						x_q <= x_q << 1;
						y_q <= y_q >> 1;
					end
					ALU_DIV: begin
						if (!diff[W]) begin
							x_q   <= diff[W-1:0];
							acc_q <= {acc_q[W-2:0], 1'b1};
						end else begin
							acc_q <= {acc_q[W-2:0], 1'b0};
						end
						y_q <= y_q >> 1;
					end
					ALU_SQRT: begin
						if (x_q >= trial) begin
							x_q   <= x_q - trial;
							acc_q <= (acc_q >> 1) + y_q;
						end else begin
							acc_q <= acc_q >> 1;
						end
						y_q <= y_q >> 2;
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
			end else if (op_q == ALU_SQRT && x_q > acc_q) begin
				// Round the root to nearest.
				acc_q <= acc_q + W'(1);
			end
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

// ----- tb/image_luminance_texture_stats_core_test.sv -----
// Testbench for the frame luminance and texture statistics core.
`timescale 1ns / 1ps
// The pixel stream is driven through plain tasks with bursty gaps. A small
// scoreboard class keeps its own copy of the frame statistics and of the
// register settings. For every accepted pixel beat it updates that copy, and
// it queues the expected result beat when the frame closes. The receiver
// stalls on a pattern of its own, and once it holds off for a long stretch
// so that the core backs up into its input. Registers are only written after
// every expected result has arrived and the core has had time to settle.
module image_luminance_texture_stats_core_test;
	import ilts_pkg::*;

	localparam int FRAME_LIMIT = 4096;
	localparam int SETTLE      = 300;
	localparam int CYCLE_LIMIT = 1500000;

	// Running statistics of the frame, as the core should hold them.
	class frame_stats_board;
		bit [12:0] width_reg;
		bit [12:0] height_reg;
		bit [16:0] thresh_reg;
		int unsigned col_cnt;
		int unsigned row_cnt;
		bit [15:0] row_luma[FRAME_LIMIT];
		bit [63:0] luma_sum;
		bit [63:0] square_sum;
		bit [63:0] texture_sum;
		bit [63:0] edge_hits;
		bit [63:0] samples;
		bit [95:0] results_due[$];

		function void clear_frame();
			col_cnt = 0;
			row_cnt = 0;
			luma_sum = 0;
			square_sum = 0;
			texture_sum = 0;
			edge_hits = 0;
			samples = 0;
		endfunction

		function void reset_all();
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			thresh_reg = THRESH_RST;
			foreach (row_luma[i]) row_luma[i] = 0;
			results_due.delete();
			clear_frame();
		endfunction

		function void write_reg(bit [1:0] idx, bit [31:0] val);
			case (idx)
				REG_WIDTH: width_reg = val[12:0];
				REG_HEIGHT: height_reg = val[12:0];
				REG_THRESH: thresh_reg = val[16:0];
				default: return;
			endcase
			clear_frame();
		endfunction

		function int unsigned clamp_size(bit [12:0] v);
			if (v == 0) return 1;
			if (v > FRAME_LIMIT) return FRAME_LIMIT;
			return 32'(v);
		endfunction

		// Square root rounded to nearest; the argument stays below 2^34.
		function bit [63:0] rounded_root(bit [63:0] s);
			bit [63:0] r;
			bit [63:0] t;
			r = 0;
			for (int k = 17; k >= 0; k--) begin
				t = r | (64'd1 << k);
				if (t * t <= s) r = t;
			end
			if (s - r * r > r) r = r + 1;
			return r;
		endfunction

		function void note_pixel(bit [7:0] red, bit [7:0] green, bit [7:0] blue);
			int unsigned w;
			int unsigned h;
			int unsigned col;
			bit [63:0] luma;
			bit [63:0] here;
			bit [63:0] right;
			bit [63:0] dx;
			bit [63:0] dy;
			bit [63:0] mag;
			bit [63:0] pixels;
			bit [63:0] mean;
			bit [127:0] num;
			bit [127:0] sub;
			bit [127:0] den;
			bit [127:0] vq;
			bit [63:0] dens;
			bit [63:0] tex;
			w = clamp_size(width_reg);
			h = clamp_size(height_reg);
			luma = (64'(LUMA_KR) * 64'(red) + 64'(LUMA_KG) * 64'(green)
				+ 64'(LUMA_KB) * 64'(blue) + 64'(LUMA_RND)) >> 8;
			col = col_cnt % FRAME_LIMIT;
			luma_sum += luma;
			square_sum += luma * luma;
			if (row_cnt % 2 == 0) begin
				row_luma[col] = luma[15:0];
			end else if (col % 2 == 0 && col + 1 < w) begin
				here = 64'(row_luma[col]);
				right = 64'(row_luma[(col + 1) % FRAME_LIMIT]);
				dx = here > right ? here - right : right - here;
				dy = here > luma ? here - luma : luma - here;
				mag = rounded_root(dx * dx + dy * dy);
				texture_sum += mag;
				if (mag > 64'(thresh_reg)) edge_hits++;
				samples++;
			end
			if (col_cnt + 1 < w) begin
				col_cnt++;
				return;
			end
			col_cnt = 0;
			if (row_cnt + 1 < h) begin
				row_cnt++;
				return;
			end
			// Last pixel of the frame: the result beat is now due.
			pixels = 64'(w) * 64'(h);
			mean = (luma_sum + pixels / 2) / pixels;
			num = 128'(pixels) * 128'(square_sum);
			sub = 128'(luma_sum) * 128'(luma_sum);
			if (num < sub) begin
				vq = 0;
			end else begin
				den = 128'(pixels) * 128'(pixels) * 128'd256;
				vq = (num - sub + den / 2) / den;
				if (vq > 128'(VAR_CAP)) vq = 128'(VAR_CAP);
			end
			if (samples != 0) begin
				dens = (edge_hits * 65536 + samples / 2) / samples;
				tex = (texture_sum + samples / 2) / samples;
			end else begin
				dens = 0;
				tex = 0;
			end
			results_due.insert(results_due.size(), {1'b0, samples[22:0], tex[16:0],
				dens[16:0], vq[21:0], mean[15:0]});
			clear_frame();
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		// Returns an empty string when the beat matches the oldest result due.
		function string check_result(bit [95:0] got);
			bit [95:0] want;
			string msg;
			msg = "";
			if (results_due.size() == 0) return "result beat with none due";
			want = results_due.pop_front();
			if (got[15:0] != want[15:0])
				msg = {msg, $sformatf(" mean %0d/%0d", got[15:0], want[15:0])};
			if (got[37:16] != want[37:16])
				msg = {msg, $sformatf(" variance %0d/%0d", got[37:16], want[37:16])};
			if (got[54:38] != want[54:38])
				msg = {msg, $sformatf(" density %0d/%0d", got[54:38], want[54:38])};
			if (got[71:55] != want[71:55])
				msg = {msg, $sformatf(" texture %0d/%0d", got[71:55], want[71:55])};
			if (got[94:72] != want[94:72])
				msg = {msg, $sformatf(" samples %0d/%0d", got[94:72], want[94:72])};
			if (got[95] != want[95]) msg = {msg, " pad bit set"};
			return msg;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	frame_stats_board stats = new();
	int errors = 0;
	int cycles = 0;
	int pixels_sent = 0;
	int burst_left = 0;
	bit hold_req = 0;

	image_luminance_texture_stats_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task report(string msg);
		$display("MISMATCH at cycle %0d:%s", cycles, msg);
		errors++;
	endtask

	// Receiver: a ready pattern that redraws its mode whenever rx_phase wraps, plus
	// one long hold-off on request so that the core fills up and stalls its input.
	int rx_mode = 0;
	int rx_phase = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		string msg;
		if (m_tvalid && m_tready) begin
			msg = stats.check_result(m_tdata);
			if (msg != "") report(msg);
		end
		if (hold_req) begin
			hold_req = 0;
			hold_left = 3000;
		end
		if (rx_phase == 0) rx_mode = $urandom_range(0, 2);
		rx_phase = (rx_phase + 1) % 64;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Called at a rising edge; returns at the edge after the one where the write lands.
	task apb_write(bit [1:0] idx, bit [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		stats.write_reg(idx, val);
		@(posedge clk);
	endtask

	task configure(bit [31:0] w, bit [31:0] h, bit [31:0] thr);
		apb_write(REG_WIDTH, w);
		apb_write(REG_HEIGHT, h);
		apb_write(REG_THRESH, thr);
	endtask

	// Offers one pixel beat and returns at the edge where it was accepted.
	task send_pixel(bit [7:0] red, bit [7:0] green, bit [7:0] blue);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {blue, green, red};
		do @(posedge clk); while (!s_tready);
		stats.note_pixel(red, green, blue);
		pixels_sent++;
	endtask

	function bit [7:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task send_random(int count);
		repeat (count) send_pixel(pick_level(), pick_level(), pick_level());
	endtask

	task send_frame();
		send_random(stats.clamp_size(stats.width_reg) * stats.clamp_size(stats.height_reg));
	endtask

	// Waits for every result due, then lets the core finish any work in flight.
	task settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (stats.pending() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int frames;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		stats.reset_all();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme pixels in a 2x2 frame with a zero threshold.
		configure(2, 2, 0);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		settle();
		// Half black, half white: the variance saturates. No sample points.
		configure(2, 1, 92320);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		settle();
		// Sizes of zero count as one; a single white pixel is a whole frame.
		configure(0, 0, 131071);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd255, 8'd0);
		settle();
		// Strong vertical edge in a 4x2 frame against a threshold no magnitude can exceed.
		configure(4, 2, 92320);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_random(4);
		settle();
		// A register write in the middle of a frame drops the pixels taken so far.
		configure(5, 4, 1000);
		send_random(7);
		settle();
		configure(3, 2, 1000);
		send_frame();
		settle();
		// Oversized width: a short run of pixels must not close the frame.
		configure(8191, 1, 5000);
		send_random(20);
		settle();
		// Oversized height in a one-pixel-wide frame: no result either.
		configure(1, 8191, 0);
		send_random(20);
		settle();
		// A wider pair of rows: many samples in one row.
		configure(64, 2, 20000);
		send_frame();
		settle();

		// Long receiver hold-off with one-pixel frames: the core must back up.
		configure(1, 1, 0);
		hold_req = 1;
		send_random(60);
		settle();

		// Random phases of small frames under changing settings.
		while (pixels_sent < 700) begin
			case ($urandom_range(0, 3))
				0: configure($urandom_range(1, 9), $urandom_range(1, 6),
					$urandom_range(0, 131071));
				1: configure($urandom_range(0, 9), $urandom_range(0, 6), 0);
				default: configure($urandom_range(1, 9), $urandom_range(1, 6),
					$urandom_range(0, 4000));
			endcase
			frames = $urandom_range(1, 3);
			repeat (frames) send_frame();
			if ($urandom_range(0, 9) == 0) send_random($urandom_range(1, 5));
			settle();
		end

		settle();
		if (stats.pending() != 0) report(" results still due at the end");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/ilts_pkg.sv
sv/ilts_ram.sv
sv/ilts_alu.sv
sv/image_luminance_texture_stats_core.sv
tb/image_luminance_texture_stats_core_test.sv
